@@ hdl/led_and_charger_pi_regulator_macros.svh @@
// Assertion macros shared by the regulator RTL.
// Stand-alone header; included by the files that carry assertions.
`ifndef LED_AND_CHARGER_PI_REGULATOR_MACROS_SVH
`define LED_AND_CHARGER_PI_REGULATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LCPR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lcpr_pkg.sv @@
// Package for the LED and charger PI regulator: constants, codes and the
// control/status structs between controller and datapath. No dependencies.
package lcpr_pkg;

    localparam int SAMPLE_COUNT_DEF = 8;
    localparam int ADC_BITS_DEF     = 10;
    localparam int NCO_BITS_DEF     = 20;

    localparam int TARGET_W    = 10;
    localparam int GAIN_W      = 16;
    localparam int BTARGET_W   = 12;
    localparam int KDIV_W      = 8;
    localparam int LIMIT_W     = 10;
    localparam int BV_W        = 16;
    localparam int PWM_W       = 10;
    localparam int CHG_INT_W   = 18;
    localparam int CFG_IDX_W   = 3;

    localparam int CHG_INT_MAX     = 130944;
    localparam int PWM_MAX         = 1023;
    localparam int BV_MAX          = 65535;
    localparam int LED_ERR_GAIN    = 20;
    localparam int NCO_INT_SHIFT   = 3;
    localparam int GAIN_SHIFT      = 11;
    localparam int CHG_P_SHIFT     = 7;
    localparam int TARGET_RESET    = 512;
    localparam int GAIN_RESET      = 2048;
    localparam int KI_RESET        = 3;
    localparam int KP_RESET        = 2;
    localparam int LIMIT_RESET     = 1023;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_LED,
        CFG_BAT_GAIN,
        CFG_BAT_TARGET,
        CFG_INT_DIV,
        CFG_PROP_DIV,
        CFG_CUR_LIMIT,
        CFG_NCO_LOW,
        CFG_NCO_HIGH
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIV_BAT,
        DIV_RAMP,
        DIV_INT,
        DIV_PROP
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BDIV,
        S_BWAIT,
        S_LED,
        S_RWAIT,
        S_IDIV,
        S_IWAIT,
        S_PDIV,
        S_PWAIT,
        S_LUPD,
        S_CHG,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_bat;
        logic     take_ramp;
        logic     ramp_clear;
        logic     take_int;
        logic     take_prop;
        logic     led_update;
        logic     chg_update;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic bat_div_needed;
        logic led_active;
        logic ramp_needed;
    } dp_status_t;

endpackage

@@ hdl/lcpr_if.sv @@
// Request channel interfaces of the regulator: input tick and result.
// Depends on nothing; widths come from interface parameters.
interface lcpr_in_if #(
    parameter int ADC_BITS = 10
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] led_voltage;
    logic [ADC_BITS-1:0] battery_sample;
    logic [ADC_BITS-1:0] led_current;
    logic                led_run;
    logic                charger_enable;
    logic                calibration_mode;
    logic                slow_ramp_arm;
    logic                fault_clear;

    modport source (
        output valid, led_voltage, battery_sample, led_current, led_run,
               charger_enable, calibration_mode, slow_ramp_arm, fault_clear,
        input  ready
    );
    modport sink (
        input  valid, led_voltage, battery_sample, led_current, led_run,
               charger_enable, calibration_mode, slow_ramp_arm, fault_clear,
        output ready
    );
endinterface

interface lcpr_out_if #(
    parameter int NCO_BITS = 20
);
    logic                valid;
    logic                ready;
    logic [NCO_BITS-1:0] nco_increment;
    logic                nco_updated;
    logic [9:0]          pwm_duty;
    logic [15:0]         battery_voltage;
    logic                led_fault;

    modport source (
        output valid, nco_increment, nco_updated, pwm_duty, battery_voltage, led_fault,
        input  ready
    );
    modport sink (
        input  valid, nco_increment, nco_updated, pwm_duty, battery_voltage, led_fault,
        output ready
    );
endinterface

@@ hdl/lcpr_divider.sv @@
// Shared unsigned restoring divider, two quotient bits per cycle.
// Uses no package; started by the datapath, one division at a time.
module lcpr_divider #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int ITER  = (NUM_W + 1) / 2;
    localparam int PW    = 2 * ITER;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [PW-1:0]    work_reg, work_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    // Two restoring steps per cycle; quotient bits shift in at the bottom.
    always_comb
    begin
        logic [DEN_W:0] trial;
        logic           qbit;
        rem_next  = rem_reg;
        work_next = work_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial = {rem_next, work_next[PW-1]};
            qbit  = (trial >= {1'b0, den_reg});
            if (qbit)
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
            end
            work_next = {work_next[PW-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ITER);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= PW'(num);
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quot = work_reg[NUM_W-1:0];

endmodule

@@ hdl/lcpr_datapath.sv @@
// Datapath of the regulator: configuration, battery filter, both PI loops,
// fault latch and result register. Uses lcpr_pkg and lcpr_divider.
module lcpr_datapath #(
    parameter int SAMPLE_COUNT = lcpr_pkg::SAMPLE_COUNT_DEF,
    parameter int ADC_BITS     = lcpr_pkg::ADC_BITS_DEF,
    parameter int NCO_BITS     = lcpr_pkg::NCO_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lcpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [NCO_BITS-1:0]              cfg_data,
    input  logic [ADC_BITS-1:0]              led_voltage,
    input  logic [ADC_BITS-1:0]              battery_sample,
    input  logic [ADC_BITS-1:0]              led_current,
    input  logic                             led_run,
    input  logic                             charger_enable,
    input  logic                             calibration_mode,
    input  logic                             slow_ramp_arm,
    input  logic                             fault_clear,
    input  lcpr_pkg::dp_cmd_t                cmd,
    output lcpr_pkg::dp_status_t             status,
    output logic [NCO_BITS-1:0]              nco_increment,
    output logic                             nco_updated,
    output logic [lcpr_pkg::PWM_W-1:0]       pwm_duty,
    output logic [lcpr_pkg::BV_W-1:0]        battery_voltage,
    output logic                             led_fault
);

    localparam int IDX_W    = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int SUM_W    = ADC_BITS + $clog2(SAMPLE_COUNT);
    localparam int HALF_W   = SUM_W - 1;
    localparam int SCALED_W = HALF_W + lcpr_pkg::GAIN_SHIFT;
    localparam int ERR_W    = NCO_BITS + 2;
    localparam int NUM_W    = (SCALED_W > NCO_BITS + 3) ? SCALED_W : NCO_BITS + 3;
    localparam int DEN_W    = lcpr_pkg::GAIN_W;
    localparam int INT_W    = NCO_BITS + 3;
    localparam int LI_W     = NCO_BITS + 6;
    localparam int SPAN_W   = NCO_BITS + 1;
    localparam int E_W      = 18;
    localparam int CI_W     = 20;
    localparam int CMP_W    = 12;

    // Configuration registers.
    logic [lcpr_pkg::TARGET_W-1:0]  target_reg;
    logic [lcpr_pkg::GAIN_W-1:0]    gain_reg;
    logic [lcpr_pkg::BTARGET_W-1:0] btarget_reg;
    logic [lcpr_pkg::KDIV_W-1:0]    ki_reg;
    logic [lcpr_pkg::KDIV_W-1:0]    kp_reg;
    logic [lcpr_pkg::LIMIT_W-1:0]   limit_reg;
    logic [NCO_BITS-1:0]            lo_reg;
    logic [NCO_BITS-1:0]            hi_reg;

    // Loop state.
    logic [ADC_BITS-1:0]            ring_reg [SAMPLE_COUNT];
    logic [IDX_W-1:0]               idx_reg;
    logic [SUM_W-1:0]               sum_reg;
    logic [INT_W-1:0]               led_int_reg;
    logic [NCO_BITS-1:0]            nco_reg;
    logic [lcpr_pkg::CHG_INT_W-1:0] chg_int_reg;
    logic                           slow_reg;
    logic                           fault_reg;

    // Per-tick working values.
    logic [ADC_BITS-1:0]            led_i_reg;
    logic                           run_reg;
    logic                           chg_reg;
    logic                           calib_reg;
    logic signed [ERR_W-1:0]        err_reg;
    logic signed [LI_W-1:0]         qi_reg;
    logic signed [LI_W-1:0]         qp_reg;
    logic [lcpr_pkg::BV_W-1:0]      bv_reg;
    logic [lcpr_pkg::PWM_W-1:0]     pwm_reg;
    logic                           upd_reg;

    // Result register.
    logic [NCO_BITS-1:0]            o_nco_reg;
    logic                           o_upd_reg;
    logic [lcpr_pkg::PWM_W-1:0]     o_pwm_reg;
    logic [lcpr_pkg::BV_W-1:0]      o_bv_reg;
    logic                           o_fault_reg;

    logic                           div_busy;
    logic [NUM_W-1:0]               div_quot;
    logic [NUM_W-1:0]               div_num;
    logic [DEN_W-1:0]               div_den;

    logic [SUM_W-1:0]               sum_next;
    logic [IDX_W-1:0]               idx_next;
    logic signed [ERR_W-1:0]        err_load;
    logic signed [SPAN_W-1:0]       span;
    logic [SPAN_W-1:0]              span_mag;
    logic [ERR_W-1:0]               err_mag;
    logic [lcpr_pkg::KDIV_W-1:0]    ki_eff;
    logic [lcpr_pkg::KDIV_W-1:0]    kp_eff;
    logic [HALF_W-1:0]              half;
    logic [lcpr_pkg::BV_W-1:0]      bv_calc;
    logic signed [LI_W-1:0]         q_signed;
    logic signed [ERR_W-1:0]        q_err;
    logic signed [LI_W-1:0]         li_clamped;
    logic [NCO_BITS-1:0]            nco_calc;
    logic [lcpr_pkg::CHG_INT_W-1:0] ci_calc;
    logic [lcpr_pkg::PWM_W-1:0]     pwm_calc;

    assign ki_eff = (ki_reg == '0) ? lcpr_pkg::KDIV_W'(1) : ki_reg;
    assign kp_eff = (kp_reg == '0) ? lcpr_pkg::KDIV_W'(1) : kp_reg;
    assign span   = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
    assign span_mag = (span < 0) ? SPAN_W'(-span) : SPAN_W'(span);
    assign err_mag  = (err_reg < 0) ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign half     = sum_reg[SUM_W-1:1];

    // Running ring sum: drop the oldest sample, add the new one.
    assign sum_next = sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(battery_sample);
    assign idx_next = (idx_reg == IDX_W'(SAMPLE_COUNT - 1)) ? '0 : idx_reg + IDX_W'(1);
    assign err_load = $signed(ERR_W'(led_voltage)) - $signed(ERR_W'(target_reg));

    // Operand selection for the shared divider.
    always_comb
    begin
        div_num = '0;
        div_den = '0;
        case (cmd.div_sel)
            lcpr_pkg::DIV_BAT:
            begin
                div_num = NUM_W'({half, {lcpr_pkg::GAIN_SHIFT{1'b0}}});
                div_den = gain_reg;
            end
            lcpr_pkg::DIV_RAMP:
            begin
                div_num = NUM_W'(span_mag);
                div_den = DEN_W'(lcpr_pkg::LED_ERR_GAIN);
            end
            lcpr_pkg::DIV_INT:
            begin
                div_num = NUM_W'(err_mag) * NUM_W'(lcpr_pkg::LED_ERR_GAIN);
                div_den = DEN_W'(ki_eff);
            end
            lcpr_pkg::DIV_PROP:
            begin
                div_num = NUM_W'(err_mag);
                div_den = DEN_W'(kp_eff);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    lcpr_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Battery voltage: raw half sum when calibrating, else corrected and saturated.
    always_comb
    begin
        if (calib_reg)
        begin
            bv_calc = lcpr_pkg::BV_W'(half);
        end
        else if (gain_reg == '0)
        begin
            bv_calc = lcpr_pkg::BV_W'(lcpr_pkg::BV_MAX);
        end
        else if (div_quot > NUM_W'(lcpr_pkg::BV_MAX))
        begin
            bv_calc = lcpr_pkg::BV_W'(lcpr_pkg::BV_MAX);
        end
        else
        begin
            bv_calc = div_quot[lcpr_pkg::BV_W-1:0];
        end
    end

    // Signed quotient: the divider works on magnitudes.
    assign q_signed = (err_reg < 0) ? -$signed(LI_W'(div_quot)) : $signed(LI_W'(div_quot));
    // Slow ramp error is minus span/20, truncated toward zero.
    assign q_err = (span < 0) ? $signed(ERR_W'(div_quot)) : -$signed(ERR_W'(div_quot));

    // LED integrator and NCO update.
    always_comb
    begin
        logic signed [LI_W-1:0] li;
        logic signed [LI_W-1:0] lo8;
        logic signed [LI_W-1:0] hi8;
        logic signed [LI_W-1:0] lo_s;
        logic signed [LI_W-1:0] hi_s;
        logic signed [LI_W-1:0] t;
        logic signed [LI_W-1:0] t_mag;
        logic signed [LI_W-1:0] n;
        li   = $signed(LI_W'(led_int_reg)) + qi_reg;
        lo8  = $signed(LI_W'({lo_reg, {lcpr_pkg::NCO_INT_SHIFT{1'b0}}}));
        hi8  = $signed(LI_W'({hi_reg, {lcpr_pkg::NCO_INT_SHIFT{1'b0}}}));
        lo_s = $signed(LI_W'(lo_reg));
        hi_s = $signed(LI_W'(hi_reg));
        if (li < lo8)
        begin
            li = lo8;
        end
        if (li > hi8)
        begin
            li = hi8;
        end
        li_clamped = li;
        t     = li + qp_reg;
        t_mag = (t < 0) ? -t : t;
        n     = t_mag >>> lcpr_pkg::NCO_INT_SHIFT;
        if (t < 0)
        begin
            n = -n;
        end
        if (n <= lo_s)
        begin
            n = lo_s;
        end
        if (n > hi_s)
        begin
            n = hi_s;
        end
        nco_calc = NCO_BITS'(n);
    end

    // Charger integrator and PWM.
    always_comb
    begin
        logic signed [E_W-1:0]  e;
        logic signed [CI_W-1:0] ci;
        logic signed [CI_W-1:0] p;
        e  = $signed(E_W'(btarget_reg)) - $signed(E_W'(bv_reg));
        ci = $signed(CI_W'(chg_int_reg)) + ($signed(CI_W'(e)) <<< 1);
        if (ci > $signed(CI_W'(lcpr_pkg::CHG_INT_MAX)))
        begin
            ci = $signed(CI_W'(lcpr_pkg::CHG_INT_MAX));
        end
        if (ci < 0)
        begin
            ci = '0;
        end
        ci_calc = lcpr_pkg::CHG_INT_W'(ci);
        p = (ci >>> lcpr_pkg::CHG_P_SHIFT) + $signed(CI_W'(e >>> 1));
        if (p < 0)
        begin
            p = '0;
        end
        if (p > $signed(CI_W'(lcpr_pkg::PWM_MAX)))
        begin
            p = $signed(CI_W'(lcpr_pkg::PWM_MAX));
        end
        pwm_calc = lcpr_pkg::PWM_W'(p);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= lcpr_pkg::TARGET_W'(lcpr_pkg::TARGET_RESET);
            gain_reg    <= lcpr_pkg::GAIN_W'(lcpr_pkg::GAIN_RESET);
            btarget_reg <= '0;
            ki_reg      <= lcpr_pkg::KDIV_W'(lcpr_pkg::KI_RESET);
            kp_reg      <= lcpr_pkg::KDIV_W'(lcpr_pkg::KP_RESET);
            limit_reg   <= lcpr_pkg::LIMIT_W'(lcpr_pkg::LIMIT_RESET);
            lo_reg      <= '0;
            hi_reg      <= '1;
        end
        else if (cfg_we)
        begin
            case (lcpr_pkg::cfg_index_t'(cfg_index))
                lcpr_pkg::CFG_TARGET_LED: target_reg  <= cfg_data[lcpr_pkg::TARGET_W-1:0];
                lcpr_pkg::CFG_BAT_GAIN:   gain_reg    <= cfg_data[lcpr_pkg::GAIN_W-1:0];
                lcpr_pkg::CFG_BAT_TARGET: btarget_reg <= cfg_data[lcpr_pkg::BTARGET_W-1:0];
                lcpr_pkg::CFG_INT_DIV:    ki_reg      <= cfg_data[lcpr_pkg::KDIV_W-1:0];
                lcpr_pkg::CFG_PROP_DIV:   kp_reg      <= cfg_data[lcpr_pkg::KDIV_W-1:0];
                lcpr_pkg::CFG_CUR_LIMIT:  limit_reg   <= cfg_data[lcpr_pkg::LIMIT_W-1:0];
                lcpr_pkg::CFG_NCO_LOW:    lo_reg      <= cfg_data;
                lcpr_pkg::CFG_NCO_HIGH:   hi_reg      <= cfg_data;
                default:                  target_reg  <= target_reg;
            endcase
        end
    end

    // Loop state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SAMPLE_COUNT; i++)
            begin
                ring_reg[i] <= '0;
            end
            idx_reg     <= '0;
            sum_reg     <= '0;
            led_int_reg <= '0;
            nco_reg     <= '0;
            chg_int_reg <= '0;
            slow_reg    <= 1'b0;
            fault_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ring_reg[idx_reg] <= battery_sample;
                idx_reg   <= idx_next;
                sum_reg   <= sum_next;
                slow_reg  <= slow_reg | slow_ramp_arm;
                fault_reg <= fault_reg & ~fault_clear;
            end
            if (cmd.ramp_clear)
            begin
                slow_reg <= 1'b0;
            end
            if (cmd.led_update)
            begin
                led_int_reg <= INT_W'(li_clamped);
                nco_reg     <= nco_calc;
            end
            if (cmd.chg_update)
            begin
                if (chg_reg)
                begin
                    chg_int_reg <= ci_calc;
                end
                if (CMP_W'(led_i_reg) >= CMP_W'(limit_reg))
                begin
                    fault_reg <= 1'b1;
                end
            end
        end
    end

    // Per-tick working values and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            led_i_reg <= led_current;
            run_reg   <= led_run;
            chg_reg   <= charger_enable;
            calib_reg <= calibration_mode;
            err_reg   <= err_load;
            upd_reg   <= 1'b0;
        end
        if (cmd.take_bat)
        begin
            bv_reg <= bv_calc;
        end
        if (cmd.take_ramp)
        begin
            err_reg <= q_err;
        end
        if (cmd.take_int)
        begin
            qi_reg <= q_signed;
        end
        if (cmd.take_prop)
        begin
            qp_reg <= q_signed;
        end
        if (cmd.led_update)
        begin
            upd_reg <= 1'b1;
        end
        if (cmd.chg_update)
        begin
            pwm_reg <= chg_reg ? pwm_calc : '0;
        end
        if (cmd.out_load)
        begin
            o_nco_reg   <= nco_reg;
            o_upd_reg   <= upd_reg;
            o_pwm_reg   <= pwm_reg;
            o_bv_reg    <= bv_reg;
            o_fault_reg <= fault_reg;
        end
    end

    assign status.div_busy       = div_busy;
    assign status.bat_div_needed = ~calib_reg & (gain_reg != '0);
    assign status.led_active     = run_reg & ~fault_reg;
    assign status.ramp_needed    = slow_reg & (err_reg < 0);

    assign nco_increment   = o_nco_reg;
    assign nco_updated     = o_upd_reg;
    assign pwm_duty        = o_pwm_reg;
    assign battery_voltage = o_bv_reg;
    assign led_fault       = o_fault_reg;

endmodule

@@ hdl/lcpr_ctrl.sv @@
// Sequencer of the regulator: walks one tick through the datapath steps.
// Uses lcpr_pkg and the assertion macro header.
`include "led_and_charger_pi_regulator_macros.svh"

module lcpr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  lcpr_pkg::dp_status_t status,
    output lcpr_pkg::dp_cmd_t    cmd
);

    lcpr_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcpr_pkg::S_IDLE:
                if (in_valid) state_next = lcpr_pkg::S_BDIV;
            lcpr_pkg::S_BDIV:
                state_next = status.bat_div_needed ? lcpr_pkg::S_BWAIT : lcpr_pkg::S_LED;
            lcpr_pkg::S_BWAIT:
                if (!status.div_busy) state_next = lcpr_pkg::S_LED;
            lcpr_pkg::S_LED:
                if (!status.led_active)      state_next = lcpr_pkg::S_CHG;
                else if (status.ramp_needed) state_next = lcpr_pkg::S_RWAIT;
                else                         state_next = lcpr_pkg::S_IDIV;
            lcpr_pkg::S_RWAIT:
                if (!status.div_busy) state_next = lcpr_pkg::S_IDIV;
            lcpr_pkg::S_IDIV:
                state_next = lcpr_pkg::S_IWAIT;
            lcpr_pkg::S_IWAIT:
                if (!status.div_busy) state_next = lcpr_pkg::S_PDIV;
            lcpr_pkg::S_PDIV:
                state_next = lcpr_pkg::S_PWAIT;
            lcpr_pkg::S_PWAIT:
                if (!status.div_busy) state_next = lcpr_pkg::S_LUPD;
            lcpr_pkg::S_LUPD:
                state_next = lcpr_pkg::S_CHG;
            lcpr_pkg::S_CHG:
                state_next = lcpr_pkg::S_DONE;
            lcpr_pkg::S_DONE:
                if (!out_valid_reg || out_ready) state_next = lcpr_pkg::S_IDLE;
            default:
                state_next = lcpr_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = (state_reg == lcpr_pkg::S_IDLE);
        case (state_reg)
            lcpr_pkg::S_IDLE:
                cmd.load = in_valid;
            lcpr_pkg::S_BDIV:
                if (status.bat_div_needed)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = lcpr_pkg::DIV_BAT;
                end
                else
                begin
                    cmd.take_bat = 1'b1;
                end
            lcpr_pkg::S_BWAIT:
                cmd.take_bat = ~status.div_busy;
            lcpr_pkg::S_LED:
                if (status.led_active && status.ramp_needed)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = lcpr_pkg::DIV_RAMP;
                end
                else if (status.led_active)
                begin
                    cmd.ramp_clear = 1'b1;
                end
            lcpr_pkg::S_RWAIT:
                cmd.take_ramp = ~status.div_busy;
            lcpr_pkg::S_IDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lcpr_pkg::DIV_INT;
            end
            lcpr_pkg::S_IWAIT:
                cmd.take_int = ~status.div_busy;
            lcpr_pkg::S_PDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lcpr_pkg::DIV_PROP;
            end
            lcpr_pkg::S_PWAIT:
                cmd.take_prop = ~status.div_busy;
            lcpr_pkg::S_LUPD:
                cmd.led_update = 1'b1;
            lcpr_pkg::S_CHG:
                cmd.chg_update = 1'b1;
            lcpr_pkg::S_DONE:
                cmd.out_load = ~out_valid_reg | out_ready;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcpr_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `LCPR_ASSERT_NEXT(a_load_starts_battery, clk, rst_n, cmd.load, state_reg == lcpr_pkg::S_BDIV, "accepted request did not start the battery step")
    `LCPR_ASSERT_SAME(a_div_start_idle, clk, rst_n, cmd.div_start, !status.div_busy, "divider started while busy")
    `LCPR_ASSERT_SAME(a_result_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready, "result overwritten before it was taken")

endmodule

@@ hdl/led_and_charger_pi_regulator.sv @@
// Top level of the LED and charger PI regulator.
// Uses lcpr_pkg, lcpr_if, lcpr_ctrl, lcpr_datapath (and lcpr_divider below it).
//
//  channel | direction | payload
//  --------+-----------+----------------------------------------------------------
//  tick    | in        | led_voltage, battery_sample, led_current, five mode flags
//  result  | out       | nco_increment, nco_updated, pwm_duty, battery_voltage,
//          |           | led_fault
//  cfg_*   | in        | write enable, register index, write data (no read-back)
//
// One request is worked on at a time. A tick runs its divisions one after another
// on the shared two-bit-per-cycle divider: a battery gain division unless
// calibrating or the gain is zero, and when the LED loop runs an integral and
// a proportional division, plus the slow ramp division when that override is
// active. The divider numerator is 23 bits wide by default. The result sits in
// an output register, so a new tick is taken while the previous result still
// waits. rst_n is asynchronous and active low; it clears the configuration to
// defaults and all loop state, including the ring.
module led_and_charger_pi_regulator #(
    parameter int SAMPLE_COUNT = lcpr_pkg::SAMPLE_COUNT_DEF,
    parameter int ADC_BITS     = lcpr_pkg::ADC_BITS_DEF,
    parameter int NCO_BITS     = lcpr_pkg::NCO_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lcpr_in_if.sink                        tick,
    lcpr_out_if.source                     result,
    input  logic                           cfg_we,
    input  logic [lcpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [NCO_BITS-1:0]            cfg_data
);

    lcpr_pkg::dp_cmd_t    cmd;
    lcpr_pkg::dp_status_t status;

    // The controller owns the handshakes and sequences the datapath steps.
    lcpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (tick.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath latches the tick on cmd.load and holds the result register.
    lcpr_datapath #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .ADC_BITS     (ADC_BITS),
        .NCO_BITS     (NCO_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .led_voltage      (tick.led_voltage),
        .battery_sample   (tick.battery_sample),
        .led_current      (tick.led_current),
        .led_run          (tick.led_run),
        .charger_enable   (tick.charger_enable),
        .calibration_mode (tick.calibration_mode),
        .slow_ramp_arm    (tick.slow_ramp_arm),
        .fault_clear      (tick.fault_clear),
        .cmd              (cmd),
        .status           (status),
        .nco_increment    (result.nco_increment),
        .nco_updated      (result.nco_updated),
        .pwm_duty         (result.pwm_duty),
        .battery_voltage  (result.battery_voltage),
        .led_fault        (result.led_fault)
    );

endmodule

@@ tb/led_and_charger_pi_regulator_tb.sv @@
// Self-checking testbench for the LED and charger PI regulator.
// Depends on lcpr_pkg, the lcpr_in_if/lcpr_out_if interfaces and the regulator RTL.
`timescale 1ns / 100ps

module led_and_charger_pi_regulator_tb;
    import lcpr_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 80;
    localparam int ITEMS_PER_PHASE = 260;
    localparam int NUM_PHASES = 6;

    typedef struct {
        logic [9:0] led_voltage;
        logic [9:0] battery_sample;
        logic [9:0] led_current;
        logic       led_run;
        logic       charger_enable;
        logic       calibration_mode;
        logic       slow_ramp_arm;
        logic       fault_clear;
    } tick_t;

    typedef struct {
        logic [19:0] nco_increment;
        logic        nco_updated;
        logic [9:0]  pwm_duty;
        logic [15:0] battery_voltage;
        logic        led_fault;
    } reg_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [19:0] cfg_data;

    lcpr_in_if  #(.ADC_BITS(10)) tick_ch ();
    lcpr_out_if #(.NCO_BITS(20)) result_ch ();

    led_and_charger_pi_regulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests still to be offered, and results the block still owes us.
    tick_t       pending_ticks[$];
    reg_result_t expected_results[$];

    int  errors;
    int  cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  tick_taken;

    // Shadow copy of the configuration registers.
    logic [9:0]  target_led;
    logic [15:0] bat_gain;
    logic [11:0] bat_target;
    logic [7:0]  int_div;
    logic [7:0]  prop_div;
    logic [9:0]  cur_limit;
    logic [19:0] nco_low;
    logic [19:0] nco_high;

    // Shadow copy of the loop state.
    logic [9:0]  bat_ring[8];
    logic [2:0]  ring_idx;
    longint      led_int;
    longint      nco_hold;
    longint      chg_int;
    bit          ramp_flag;
    bit          fault_flag;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mirrors the regulator for one accepted tick and returns what it must report.
    task automatic compute_regulation(input tick_t t, output reg_result_t r);
        longint sum, bv, q, lo, hi, ki, kp, lv, tgt, err, n, e, pwm, bt;
        bit     updated;
        begin
            updated = 1'b0;
            pwm = 0;
            if (t.slow_ramp_arm) ramp_flag = 1'b1;
            if (t.fault_clear) fault_flag = 1'b0;

            // Battery moving sum over the ring, halved, then gain corrected outside calibration.
            bat_ring[ring_idx] = t.battery_sample;
            ring_idx = ring_idx + 3'd1;
            sum = 0;
            for (int k = 0; k < 8; k++) sum += bat_ring[k];
            bv = sum >>> 1;
            if (!t.calibration_mode)
            begin
                if (bat_gain == 0)
                    q = BV_MAX;
                else
                    q = (bv <<< GAIN_SHIFT) / longint'({48'd0, bat_gain});
                bv = (q > BV_MAX) ? BV_MAX : q;
            end

            // LED loop runs only when the LED is on and no fault is latched.
            if (t.led_run && !fault_flag)
            begin
                lo = {44'd0, nco_low};
                hi = {44'd0, nco_high};
                ki = (int_div == 0) ? 1 : {56'd0, int_div};
                kp = (prop_div == 0) ? 1 : {56'd0, prop_div};
                lv = {54'd0, t.led_voltage};
                tgt = {54'd0, target_led};
                err = lv - tgt;
                if (ramp_flag)
                begin
                    if (err < 0)
                        err = -((hi - lo) / LED_ERR_GAIN);
                    else
                        ramp_flag = 1'b0;
                end
                led_int += (err * LED_ERR_GAIN) / ki;
                if (led_int < lo * 8) led_int = lo * 8;
                if (led_int > hi * 8) led_int = hi * 8;
                n = (led_int + err / kp) / 8;
                if (n <= lo) n = lo;
                if (n > hi) n = hi;
                nco_hold = n;
                updated = 1'b1;
            end

            // Charger loop; the proportional half rounds toward minus infinity.
            if (t.charger_enable)
            begin
                bt = {52'd0, bat_target};
                e = bt - bv;
                chg_int += e * 2;
                if (chg_int > CHG_INT_MAX) chg_int = CHG_INT_MAX;
                if (chg_int < 0) chg_int = 0;
                pwm = chg_int / 128 + ((e >= 0) ? e / 2 : -((-e + 1) / 2));
                if (pwm < 0) pwm = 0;
                if (pwm > PWM_MAX) pwm = PWM_MAX;
            end

            if (t.led_current >= cur_limit) fault_flag = 1'b1;

            r.nco_increment   = nco_hold[19:0];
            r.nco_updated     = updated;
            r.pwm_duty        = pwm[9:0];
            r.battery_voltage = bv[15:0];
            r.led_fault       = fault_flag;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
            errors++;
        end
    endtask

    // Driver: presents the next pending request at the falling edge, with random gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!tick_ch.valid || tick_taken))
        begin
            tick_taken = 1'b0;
            if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                tick_t t;
                t = pending_ticks.pop_front();
                tick_ch.led_voltage      <= t.led_voltage;
                tick_ch.battery_sample   <= t.battery_sample;
                tick_ch.led_current      <= t.led_current;
                tick_ch.led_run          <= t.led_run;
                tick_ch.charger_enable   <= t.charger_enable;
                tick_ch.calibration_mode <= t.calibration_mode;
                tick_ch.slow_ramp_arm    <= t.slow_ramp_arm;
                tick_ch.fault_clear      <= t.fault_clear;
                tick_ch.valid            <= 1'b1;
            end
            else
            begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // Result back-pressure, also changed only at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: an accepted request feeds the predictor, an accepted result is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                tick_t t;
                reg_result_t r;
                t.led_voltage      = tick_ch.led_voltage;
                t.battery_sample   = tick_ch.battery_sample;
                t.led_current      = tick_ch.led_current;
                t.led_run          = tick_ch.led_run;
                t.charger_enable   = tick_ch.charger_enable;
                t.calibration_mode = tick_ch.calibration_mode;
                t.slow_ramp_arm    = tick_ch.slow_ramp_arm;
                t.fault_clear      = tick_ch.fault_clear;
                compute_regulation(t, r);
                expected_results.push_back(r);
                tick_taken = 1'b1;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("UNEXPECTED result with nothing outstanding (t=%0t)", $realtime);
                    errors++;
                end
                else
                begin
                    reg_result_t w;
                    w = expected_results.pop_front();
                    if (result_ch.nco_increment !== w.nco_increment)
                        report_mismatch("nco_increment", result_ch.nco_increment,
                                        w.nco_increment);
                    if (result_ch.nco_updated !== w.nco_updated)
                        report_mismatch("nco_updated", result_ch.nco_updated, w.nco_updated);
                    if (result_ch.pwm_duty !== w.pwm_duty)
                        report_mismatch("pwm_duty", result_ch.pwm_duty, w.pwm_duty);
                    if (result_ch.battery_voltage !== w.battery_voltage)
                        report_mismatch("battery_voltage", result_ch.battery_voltage,
                                        w.battery_voltage);
                    if (result_ch.led_fault !== w.led_fault)
                        report_mismatch("led_fault", result_ch.led_fault, w.led_fault);
                end
            end
        end
    end

    // Watchdog in case the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("led_and_charger_pi_regulator test failed");
            $finish;
        end
    end

    // Register write, applied at the falling edge and taken at the next rising edge.
    task automatic write_register(input cfg_index_t idx, input logic [19:0] value);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(negedge clk);
            cfg_we    <= 1'b0;
            case (idx)
                CFG_TARGET_LED: target_led = value[9:0];
                CFG_BAT_GAIN:   bat_gain   = value[15:0];
                CFG_BAT_TARGET: bat_target = value[11:0];
                CFG_INT_DIV:    int_div    = value[7:0];
                CFG_PROP_DIV:   prop_div   = value[7:0];
                CFG_CUR_LIMIT:  cur_limit  = value[9:0];
                CFG_NCO_LOW:    nco_low    = value;
                CFG_NCO_HIGH:   nco_high   = value;
                default: ;
            endcase
        end
    endtask

    task automatic write_all(input logic [9:0] tgt, input logic [15:0] gain,
                             input logic [11:0] btgt, input logic [7:0] ki,
                             input logic [7:0] kp, input logic [9:0] lim,
                             input logic [19:0] lo, input logic [19:0] hi);
        begin
            write_register(CFG_TARGET_LED, {10'd0, tgt});
            write_register(CFG_BAT_GAIN, {4'd0, gain});
            write_register(CFG_BAT_TARGET, {8'd0, btgt});
            write_register(CFG_INT_DIV, {12'd0, ki});
            write_register(CFG_PROP_DIV, {12'd0, kp});
            write_register(CFG_CUR_LIMIT, {10'd0, lim});
            write_register(CFG_NCO_LOW, lo);
            write_register(CFG_NCO_HIGH, hi);
        end
    endtask

    // Waits until every request went in and every result came out, then lets
    // the block settle before the configuration may change again.
    task automatic wait_until_idle();
        begin
            while (pending_ticks.size() > 0 || tick_ch.valid || expected_results.size() > 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    function automatic tick_t build_tick(input logic [9:0] lv, input logic [9:0] bs,
                                         input logic [9:0] li, input logic [4:0] flags);
        tick_t t;
        t.led_voltage      = lv;
        t.battery_sample   = bs;
        t.led_current      = li;
        t.led_run          = flags[4];
        t.charger_enable   = flags[3];
        t.calibration_mode = flags[2];
        t.slow_ramp_arm    = flags[1];
        t.fault_clear      = flags[0];
        return t;
    endfunction

    // Mostly well-behaved ticks near the setpoint, below the current limit, with
    // occasional full-range values, ramp arming and fault clearing.
    function automatic tick_t random_tick();
        tick_t t;
        int    lv;
        t.battery_sample = $urandom_range(1023);
        if ($urandom_range(99) < 70)
        begin
            lv = int'(target_led) + $urandom_range(80) - 40;
            if (lv < 0) lv = 0;
            if (lv > 1023) lv = 1023;
            t.led_voltage = lv[9:0];
        end
        else
        begin
            t.led_voltage = $urandom_range(1023);
        end
        if ($urandom_range(99) < 88 && cur_limit > 0)
            t.led_current = $urandom_range(int'(cur_limit) - 1);
        else
            t.led_current = $urandom_range(1023);
        t.led_run          = ($urandom_range(99) < 90);
        t.charger_enable   = ($urandom_range(99) < 80);
        t.calibration_mode = ($urandom_range(99) < 15);
        t.slow_ramp_arm    = ($urandom_range(99) < 6);
        t.fault_clear      = ($urandom_range(99) < 20);
        return t;
    endfunction

    // Each phase picks its own settings; the fixed ones hit the extremes.
    task automatic configure_phase(input int p);
        begin
            case (p)
                0: write_all($urandom_range(1023), 1, 0, 255, 1, 1023, 0, 20'hFFFFF);
                1: write_all($urandom_range(1023), 16'hFFFF, 12'hFFF, 1, 255, 900, 0, 20'hFFFFF);
                2: write_all(512, 0, $urandom_range(4095), 0, 0, 1000, 900000, 100000);
                3: write_all(1023, $urandom_range(1, 65535), 12'hFFF, $urandom_range(1, 255),
                             $urandom_range(1, 255), $urandom_range(700, 1023),
                             $urandom_range(0, 300000), $urandom_range(600000, 1048575));
                4: write_all(0, $urandom_range(1500, 2600), $urandom_range(4095),
                             $urandom_range(1, 255), $urandom_range(1, 255), 0,
                             20'hFFFFF, 20'hFFFFF);
                default: write_all($urandom_range(1023), $urandom_range(65535),
                                   $urandom_range(4095), $urandom_range(255),
                                   $urandom_range(255), $urandom_range(500, 1023),
                                   $urandom_range(1048575), $urandom_range(1048575));
            endcase
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        tick_taken = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 68;
        cfg_we = 1'b0;
        cfg_index = CFG_TARGET_LED;
        cfg_data = '0;
        tick_ch.valid = 1'b0;
        tick_ch.led_voltage = '0;
        tick_ch.battery_sample = '0;
        tick_ch.led_current = '0;
        tick_ch.led_run = 1'b0;
        tick_ch.charger_enable = 1'b0;
        tick_ch.calibration_mode = 1'b0;
        tick_ch.slow_ramp_arm = 1'b0;
        tick_ch.fault_clear = 1'b0;
        result_ch.ready = 1'b0;

        // Shadow state starts at the reset values of the block.
        target_led = TARGET_RESET;
        bat_gain   = GAIN_RESET;
        bat_target = 0;
        int_div    = KI_RESET;
        prop_div   = KP_RESET;
        cur_limit  = LIMIT_RESET;
        nco_low    = 0;
        nco_high   = 20'hFFFFF;
        for (int k = 0; k < 8; k++) bat_ring[k] = '0;
        ring_idx   = '0;
        led_int    = 0;
        nco_hold   = 0;
        chg_int    = 0;
        ramp_flag  = 1'b0;
        fault_flag = 1'b0;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed ticks first under the reset settings, with a battery target
        // that keeps the charger loop busy. Flag order: run, charger, calib,
        // ramp arm, fault clear.
        write_register(CFG_BAT_TARGET, 12'hFFF);
        pending_ticks.push_back(build_tick(10'd0, 10'd0, 10'd0, 5'b11000));
        pending_ticks.push_back(build_tick(10'd1023, 10'd1023, 10'd0, 5'b11000));
        pending_ticks.push_back(build_tick(10'd1023, 10'd1023, 10'd0, 5'b11100));
        pending_ticks.push_back(build_tick(10'd512, 10'd1023, 10'd0, 5'b01000));
        pending_ticks.push_back(build_tick(10'd1023, 10'd1023, 10'd0, 5'b11000));
        // Slow ramp armed: a negative error is overridden, a non-negative one clears it.
        pending_ticks.push_back(build_tick(10'd0, 10'd500, 10'd0, 5'b11010));
        pending_ticks.push_back(build_tick(10'd100, 10'd500, 10'd0, 5'b11000));
        pending_ticks.push_back(build_tick(10'd600, 10'd500, 10'd0, 5'b11000));
        pending_ticks.push_back(build_tick(10'd0, 10'd500, 10'd0, 5'b11000));
        // Overcurrent at the limit latches, LED loop then holds until cleared.
        pending_ticks.push_back(build_tick(10'd700, 10'd300, 10'd1023, 5'b11000));
        pending_ticks.push_back(build_tick(10'd700, 10'd300, 10'd0, 5'b11000));
        pending_ticks.push_back(build_tick(10'd700, 10'd300, 10'd0, 5'b10000));
        pending_ticks.push_back(build_tick(10'd700, 10'd300, 10'd0, 5'b11001));
        pending_ticks.push_back(build_tick(10'd700, 10'd300, 10'd1023, 5'b11001));
        pending_ticks.push_back(build_tick(10'd700, 10'd0, 10'd0, 5'b11001));
        pending_ticks.push_back(build_tick(10'd300, 10'd0, 10'd512, 5'b00110));
        pending_ticks.push_back(build_tick(10'd1023, 10'd0, 10'd1022, 5'b11111));
        pending_ticks.push_back(build_tick(10'd0, 10'd0, 10'd0, 5'b11100));
        for (int k = 0; k < 4; k++)
            pending_ticks.push_back(build_tick(10'd0, 10'd0, 10'd0, 5'b11000));
        wait_until_idle();

        // Random phases: sender light and receiver heavy idling, then the
        // reverse, then none at all.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 68;
            end
            else if (p < 4)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure_phase(p);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                pending_ticks.push_back(random_tick());
            wait_until_idle();
        end

        if (errors == 0)
            $display("led_and_charger_pi_regulator test passed");
        else
            $display("led_and_charger_pi_regulator test failed");
        $finish;
    end

endmodule
